// ===== design/bucketed_name_hash_table_unit_macros.svh =====
// Assertion macros shared by the checker of the bucketed name hash table.
`ifndef BUCKETED_NAME_HASH_TABLE_UNIT_MACROS_SVH
`define BUCKETED_NAME_HASH_TABLE_UNIT_MACROS_SVH

// Condition a implies condition b in the same cycle.
`define BNHT_ASSERT_IMPLY(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("bnht check failed");

// Condition a implies condition b in the following cycle.
`define BNHT_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("bnht check failed");

`endif

// ===== design/bnht_pkg.sv =====
// ----------------------------------------------------------------------------
// bnht_pkg
// Types, codes and defaults shared by the bucketed name hash table files.
// ----------------------------------------------------------------------------
package bnht_pkg;

    localparam int BUCKETS_DEF  = 64;
    localparam int SLOTS_DEF    = 8;
    localparam int NAME_LEN_DEF = 32;
    localparam int ID_WIDTH_DEF = 16;

    localparam int HASH_W    = 64;
    localparam int BKT_MAX_W = 12;
    localparam int STATUS_W  = 3;
    localparam int FID_W     = 17;
    localparam int SLOTIDX_W = 4;
    localparam int BKTIDX_W  = 6;
    localparam int OP_W      = 2;
    localparam int EID_W     = 16;

    localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BKT_EMPTY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd5;

    localparam logic [FID_W-1:0] FID_NONE = '1;

    // Commands from the sequencer to the hash unit.
    typedef struct packed {
        logic       add_byte;
        logic       add_fin;
        logic [7:0] data;
    } hash_cmd_t;

    // Status from the hash unit.
    typedef struct packed {
        logic                 busy;
        logic [BKT_MAX_W-1:0] rem;
    } hash_stat_t;

endpackage

// ===== design/bnht_hash.sv =====
// ----------------------------------------------------------------------------
// bnht_hash
// Shared 64-bit adder for the running hash and a digit-wise bucket reduction.
// ----------------------------------------------------------------------------
module bnht_hash #(
    parameter int BUCKETS = bnht_pkg::BUCKETS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bnht_pkg::hash_cmd_t   cmd,
    output bnht_pkg::hash_stat_t  stat
);
    import bnht_pkg::*;

    localparam int BW     = $clog2(BUCKETS);
    localparam int DW     = 16;
    localparam int XW     = BW + DW;
    localparam int PW     = 2 * XW;
    localparam int PHASES = 2 * (HASH_W / DW);
    localparam logic [XW-1:0] RECIP = XW'((64'd1 << XW) / 64'(BUCKETS));

    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [BW-1:0]     rem_reg, rem_next;
    logic [XW-1:0]     quo_reg, quo_next;
    logic [HASH_W-1:0] sum;
    logic [XW-1:0]     x;
    logic [PW-1:0]     prod;
    logic [XW-1:0]     qb;
    logic [XW-1:0]     r_raw;

    // One adder serves both the per-byte update and the final multiply by 33.
    assign sum = hash_reg + {hash_reg[HASH_W-6:0], 5'b0}
                 + HASH_W'(cmd.add_byte ? cmd.data : 8'd0);

    // The next 16-bit digit joined below the running remainder.
    assign x = {rem_reg, hash_reg[HASH_W-1 -: DW]};

    // The reciprocal gives a quotient that is exact or one short, so the
    // remainder needs at most one further subtraction of the bucket count.
    assign prod  = PW'(x) * PW'(RECIP);
    assign qb    = XW'(PW'(quo_reg) * PW'(BUCKETS));
    assign r_raw = x - qb;

    always_comb begin
        hash_next = hash_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (cnt_reg != 4'd0) begin
            cnt_next = cnt_reg - 4'd1;
            if (!cnt_reg[0]) begin
                quo_next = XW'(prod >> XW);
            end else begin
                // The hash shifts out as it is reduced, so it ends at zero.
                hash_next = {hash_reg[HASH_W-DW-1:0], {DW{1'b0}}};
                if (r_raw >= XW'(BUCKETS)) begin
                    rem_next = BW'(r_raw - XW'(BUCKETS));
                end else begin
                    rem_next = BW'(r_raw);
                end
            end
        end else if (cmd.add_fin) begin
            hash_next = sum;
            cnt_next  = 4'(PHASES);
            rem_next  = '0;
        end else if (cmd.add_byte) begin
            hash_next = sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            hash_reg <= hash_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = (cnt_reg != 4'd0);
    assign stat.rem  = BKT_MAX_W'(rem_reg);

endmodule

// ===== design/bucketed_name_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// bucketed_name_hash_table_unit
// Name table of fixed buckets addressed by a multiply-by-33 hash, fed a byte per beat.
// ----------------------------------------------------------------------------
// A name arrives one byte per input beat, the operation in tuser and tlast
// on the final byte. The block stays ready until the last byte beat. After
// that beat it is not ready while it finishes the hash, reduces it to a
// bucket a 16-bit digit at a time by reciprocal multiplication, a quotient
// step and then a remainder step per digit, and then issues the read of
// the bucket's valid row, decides on that row and then walks the bucket:
// an insert copies the name a byte at a time, each read from the name
// buffer and then written, and then sets the slot's length, id and valid
// bit; a find or remove steps over free slots, reads the length of each
// occupied slot and compares the bytes of a slot whose length matches,
// one byte at a time; the result then goes to the output register. An
// empty or too long name skips the read and the walk. The time of a find
// or remove is set by the slot walk and the single port of the stored-name
// memory, plus any wait for the result register to empty. After reset a
// clearing pass empties every bucket before the first beat is taken. One
// result beat leaves per name; it waits in an output register while the
// next name's bytes are already being taken.
module bucketed_name_hash_table_unit #(
    parameter int BUCKETS  = bnht_pkg::BUCKETS_DEF,
    parameter int SLOTS    = bnht_pkg::SLOTS_DEF,
    parameter int NAME_LEN = bnht_pkg::NAME_LEN_DEF,
    parameter int ID_WIDTH = bnht_pkg::ID_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // name_char[7:0], entry_id[23:8]
    input  logic [1:0]  s_tuser,   // op[1:0]
    input  logic        s_tlast,   // name_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // found_id[16:0], slot_index[20:17],
                                   // bucket_index[26:21], zeros above
    output logic [2:0]  m_tuser    // status[2:0]
);
    import bnht_pkg::*;

    localparam int TOTAL = BUCKETS * SLOTS;
    localparam int SW    = $clog2(TOTAL);
    localparam int MW    = $clog2(TOTAL * NAME_LEN);
    localparam int AW    = $clog2(NAME_LEN);
    localparam int LW    = $clog2(NAME_LEN + 1);
    localparam int BW    = $clog2(BUCKETS);
    localparam int SCW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [13:0] {
        S_CLEAR  = 14'b00000000000001,
        S_BYTE   = 14'b00000000000010,
        S_FIN    = 14'b00000000000100,
        S_MOD    = 14'b00000000001000,
        S_DECIDE = 14'b00000000010000,
        S_CP_RD  = 14'b00000000100000,
        S_CP_WR  = 14'b00000001000000,
        S_CP_FIN = 14'b00000010000000,
        S_SCAN   = 14'b00000100000000,
        S_LCK    = 14'b00001000000000,
        S_CMP_RD = 14'b00010000000000,
        S_CMP_CK = 14'b00100000000000,
        S_EMIT   = 14'b01000000000000,
        S_SPARE  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // Name assembly.
    logic [LW-1:0]       len_reg, len_next;
    logic                ended_reg, ended_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [ID_WIDTH-1:0] id_reg, id_next;

    // Walk counters.
    logic [BW-1:0]  bkt_reg, bkt_next;
    logic [SCW-1:0] slot_reg, slot_next;
    logic [LW-1:0]  j_reg, j_next;
    logic [BW-1:0]  clr_reg, clr_next;

    // Result held until the output register is free.
    logic [STATUS_W-1:0]  res_st_reg, res_st_next;
    logic [FID_W-1:0]     res_fid_reg, res_fid_next;
    logic [SLOTIDX_W-1:0] res_slot_reg, res_slot_next;
    logic [BKTIDX_W-1:0]  res_bkt_reg, res_bkt_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;
    logic [2:0]  m_tuser_reg, m_tuser_next;

    hash_cmd_t  hcmd;
    hash_stat_t hstat;

    // Memories and their registered read data.
    logic [7:0]          buf_mem [NAME_LEN];
    logic [7:0]          nm_mem  [TOTAL * NAME_LEN];
    logic [LW-1:0]       len_mem [TOTAL];
    logic [ID_WIDTH-1:0] id_mem  [TOTAL];
    logic [SLOTS-1:0]    vld_mem [BUCKETS];

    logic [7:0]          buf_q, nm_q;
    logic [LW-1:0]       len_q;
    logic [ID_WIDTH-1:0] id_q;
    logic [SLOTS-1:0]    row_q;

    logic                buf_we;
    logic                nm_we;
    logic                meta_we;
    logic                vld_we, vld_re;
    logic [BW-1:0]       vld_waddr, vld_raddr;
    logic [SLOTS-1:0]    vld_wdata;
    logic [SW-1:0]       slot_full;
    logic [MW-1:0]       nm_addr;
    logic [SLOTS-1:0]    slot_bit;
    logic [SCW-1:0]      first_free;
    logic                accept;
    logic [7:0]          in_char;

    bnht_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (hcmd),
        .stat    (hstat)
    );

    assign accept    = s_tvalid && s_tready;
    assign in_char   = s_tdata[7:0];
    assign slot_full = SW'(bkt_reg) * SW'(SLOTS) + SW'(slot_reg);
    assign nm_addr   = MW'(slot_full) * MW'(NAME_LEN) + MW'(j_reg);
    assign slot_bit  = SLOTS'(1) << slot_reg;

    // Lowest free slot of the bucket row just read.
    always_comb begin
        first_free = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!row_q[i]) begin
                first_free = SCW'(i);
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        ended_next    = ended_reg;
        op_next       = op_reg;
        id_next       = id_reg;
        bkt_next      = bkt_reg;
        slot_next     = slot_reg;
        j_next        = j_reg;
        clr_next      = clr_reg;
        res_st_next   = res_st_reg;
        res_fid_next  = res_fid_reg;
        res_slot_next = res_slot_reg;
        res_bkt_next  = res_bkt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        hcmd          = '{add_byte: 1'b0, add_fin: 1'b0, data: in_char};
        buf_we        = 1'b0;
        nm_we         = 1'b0;
        meta_we       = 1'b0;
        vld_we        = 1'b0;
        vld_re        = 1'b0;
        vld_waddr     = bkt_reg;
        vld_raddr     = BW'(hstat.rem);
        vld_wdata     = row_q;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                vld_we    = 1'b1;
                vld_waddr = clr_reg;
                vld_wdata = '0;
                clr_next  = clr_reg + BW'(1);
                if (clr_reg == BW'(BUCKETS - 1)) begin
                    state_next = S_BYTE;
                end
            end
            S_BYTE: begin
                if (accept) begin
                    // A zero byte ends the name; later bytes are ignored.
                    if (!ended_reg) begin
                        if (in_char == 8'd0) begin
                            ended_next = 1'b1;
                        end else if (len_reg >= LW'(NAME_LEN - 1)) begin
                            len_next = LW'(NAME_LEN);
                        end else begin
                            buf_we        = 1'b1;
                            len_next      = len_reg + LW'(1);
                            hcmd.add_byte = 1'b1;
                        end
                    end
                    if (s_tlast) begin
                        op_next    = s_tuser;
                        id_next    = ID_WIDTH'(s_tdata[23:8]);
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN: begin
                hcmd.add_fin = 1'b1;
                state_next   = S_MOD;
            end
            S_MOD: begin
                if (!hstat.busy) begin
                    bkt_next     = BW'(hstat.rem);
                    res_fid_next = FID_NONE;
                    res_slot_next = '0;
                    res_bkt_next = BKTIDX_W'(BW'(hstat.rem));
                    if (len_reg == LW'(NAME_LEN)) begin
                        res_st_next  = ST_TOO_LONG;
                        res_bkt_next = '0;
                        state_next   = S_EMIT;
                    end else if (len_reg == '0) begin
                        res_st_next = ST_EMPTY;
                        state_next  = S_EMIT;
                    end else begin
                        vld_re     = 1'b1;
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                j_next = '0;
                if (op_reg == OP_INSERT) begin
                    if (&row_q) begin
                        res_st_next = ST_FULL;
                        state_next  = S_EMIT;
                    end else begin
                        slot_next  = first_free;
                        state_next = S_CP_RD;
                    end
                end else if (~|row_q) begin
                    res_st_next = ST_BKT_EMPTY;
                    state_next  = S_EMIT;
                end else begin
                    slot_next  = '0;
                    state_next = S_SCAN;
                end
            end
            S_CP_RD: begin
                state_next = S_CP_WR;
            end
            S_CP_WR: begin
                nm_we = 1'b1;
                if (j_reg == len_reg - LW'(1)) begin
                    state_next = S_CP_FIN;
                end else begin
                    j_next     = j_reg + LW'(1);
                    state_next = S_CP_RD;
                end
            end
            S_CP_FIN: begin
                meta_we       = 1'b1;
                vld_we        = 1'b1;
                vld_wdata     = row_q | slot_bit;
                res_st_next   = ST_OK;
                res_slot_next = SLOTIDX_W'(slot_reg) + SLOTIDX_W'(1);
                state_next    = S_EMIT;
            end
            S_SCAN: begin
                j_next = '0;
                if (row_q[slot_reg]) begin
                    state_next = S_LCK;
                end else if (slot_reg == SCW'(SLOTS - 1)) begin
                    res_st_next = ST_NOT_FOUND;
                    state_next  = S_EMIT;
                end else begin
                    slot_next = slot_reg + SCW'(1);
                end
            end
            S_LCK: begin
                if (len_q == len_reg) begin
                    state_next = S_CMP_RD;
                end else if (slot_reg == SCW'(SLOTS - 1)) begin
                    res_st_next = ST_NOT_FOUND;
                    state_next  = S_EMIT;
                end else begin
                    slot_next  = slot_reg + SCW'(1);
                    state_next = S_SCAN;
                end
            end
            S_CMP_RD: begin
                state_next = S_CMP_CK;
            end
            S_CMP_CK: begin
                if (nm_q != buf_q) begin
                    if (slot_reg == SCW'(SLOTS - 1)) begin
                        res_st_next = ST_NOT_FOUND;
                        state_next  = S_EMIT;
                    end else begin
                        slot_next  = slot_reg + SCW'(1);
                        state_next = S_SCAN;
                    end
                end else if (j_reg == len_reg - LW'(1)) begin
                    res_st_next   = ST_OK;
                    res_slot_next = SLOTIDX_W'(slot_reg) + SLOTIDX_W'(1);
                    if (op_reg == OP_REMOVE) begin
                        vld_we    = 1'b1;
                        vld_wdata = row_q & ~slot_bit;
                    end else begin
                        res_fid_next = FID_W'(id_q);
                    end
                    state_next = S_EMIT;
                end else begin
                    j_next     = j_reg + LW'(1);
                    state_next = S_CMP_RD;
                end
            end
            S_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_st_reg;
                    m_tdata_next  = {5'b0, res_bkt_reg, res_slot_reg, res_fid_reg};
                    len_next      = '0;
                    ended_next    = 1'b0;
                    state_next    = S_BYTE;
                end
            end
            default: begin
                state_next = S_BYTE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            len_reg      <= '0;
            ended_reg    <= 1'b0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            ended_reg    <= ended_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg       <= op_next;
        id_reg       <= id_next;
        bkt_reg      <= bkt_next;
        slot_reg     <= slot_next;
        j_reg        <= j_next;
        res_st_reg   <= res_st_next;
        res_fid_reg  <= res_fid_next;
        res_slot_reg <= res_slot_next;
        res_bkt_reg  <= res_bkt_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    // Name buffer: written at the fill position, read at the walk position.
    always_ff @(posedge aclk) begin
        if (buf_we) begin
            buf_mem[len_reg[AW-1:0]] <= in_char;
        end
        buf_q <= buf_mem[j_reg[AW-1:0]];
    end

    // Stored name bytes: a single port, written on copy, read otherwise.
    always_ff @(posedge aclk) begin
        if (nm_we) begin
            nm_mem[nm_addr] <= buf_q;
        end else begin
            nm_q <= nm_mem[nm_addr];
        end
    end

    // Per-slot length and id.
    always_ff @(posedge aclk) begin
        if (meta_we) begin
            len_mem[slot_full] <= len_reg;
            id_mem[slot_full]  <= id_reg;
        end
        len_q <= len_mem[slot_full];
        id_q  <= id_mem[slot_full];
    end

    // One row of valid bits per bucket.
    always_ff @(posedge aclk) begin
        if (vld_we) begin
            vld_mem[vld_waddr] <= vld_wdata;
        end
        if (vld_re) begin
            row_q <= vld_mem[vld_raddr];
        end
    end

    assign s_tready = (state_reg == S_BYTE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== design/bnht_checker.sv =====
// ----------------------------------------------------------------------------
// bnht_checker
// Port-level checks on the result channel of the bucketed name hash table.
// ----------------------------------------------------------------------------
`include "bucketed_name_hash_table_unit_macros.svh"

module bnht_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);
    import bnht_pkg::*;

    `BNHT_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `BNHT_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
    `BNHT_ASSERT_IMPLY(a_fail_no_id, aclk, aresetn, m_tvalid && m_tuser != ST_OK, m_tdata[16:0] == FID_NONE && m_tdata[20:17] == 4'd0)
    `BNHT_ASSERT_IMPLY(a_long_bucket, aclk, aresetn, m_tvalid && m_tuser == ST_TOO_LONG, m_tdata[26:21] == 6'd0)
    `BNHT_ASSERT_IMPLY(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[31:27] == 5'd0)

endmodule

bind bucketed_name_hash_table_unit bnht_checker u_bnht_checker (.*);
